// ----- hw/rtl/piecewise_cubic_knot_spline_unit_defines.svh -----
// assertion macros shared by the spline unit
`ifndef PIECEWISE_CUBIC_KNOT_SPLINE_UNIT_DEFINES_SVH
`define PIECEWISE_CUBIC_KNOT_SPLINE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcks: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PCKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcks: next-cycle check failed");

`endif

// ----- hw/rtl/pcks_pkg.sv -----
// ----------------------------------------------------------------------------
// pcks_pkg
// Shared types and constants of the piecewise cubic knot spline unit.
// ----------------------------------------------------------------------------
package pcks_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    // queue address field sized for the largest supported table
    localparam int ADDR_W = 10;
    // coefficient and horner accumulator width, 27 * 2^31 bounds every value
    localparam int ACC_W  = 37;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [CFG_W-1:0] KNOT_COUNT_RESET = 7'd4;
    localparam logic [CFG_W-1:0] MIN_KNOTS        = 7'd4;
    localparam logic [CFG_W-1:0] SPAN_OFFSET      = 7'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EVAL,
        OP_LAST,
        OP_ERR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;   // load slot, window base or last knot
        logic [DATA_W-1:0]  data;   // knot value or fraction
    } t_entry;

endpackage

// ----- hw/rtl/pcks_in_if.sv -----
// ----------------------------------------------------------------------------
// pcks_in_if
// Input channel: load and evaluate commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcks_in_if;

    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [pcks_pkg::IDX_W-1:0]          knot_index;
    logic signed [pcks_pkg::DATA_W-1:0]  knot_value;
    logic signed [pcks_pkg::DATA_W-1:0]  position;

    modport source (
        output valid, command, knot_index, knot_value, position,
        input  ready
    );

    modport sink (
        input  valid, command, knot_index, knot_value, position,
        output ready
    );

endinterface

// ----- hw/rtl/pcks_out_if.sv -----
// ----------------------------------------------------------------------------
// pcks_out_if
// Output channel: evaluated spline value and status with valid/ready.
// ----------------------------------------------------------------------------
interface pcks_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [pcks_pkg::DATA_W-1:0]  spline_value;
    logic                                status;

    modport source (
        output valid, spline_value, status,
        input  ready
    );

    modport sink (
        input  valid, spline_value, status,
        output ready
    );

endinterface

// ----- hw/rtl/pcks_front.sv -----
// ----------------------------------------------------------------------------
// pcks_front
// Accepts items, holds knot_count, clamps and scales the position and
// classifies each item into a queue entry for the back end.
// ----------------------------------------------------------------------------
module pcks_front #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcks_pkg::CFG_W-1:0]     i_cfg_data,
    pcks_in_if.sink                        i_in,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output pcks_pkg::t_entry               o_push_data
);

    localparam int PW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 1 + pcks_pkg::CFG_W;
    localparam int SW = TW - FRAC_BITS;
    localparam logic [pcks_pkg::DATA_W-1:0] ONE_FX = pcks_pkg::DATA_W'(1) << FRAC_BITS;

    logic [pcks_pkg::CFG_W-1:0] r_knot_count;

    logic [pcks_pkg::CFG_W-1:0] knots_used;
    logic [pcks_pkg::CFG_W-1:0] spans;
    logic [PW-1:0]              pos_clamped;
    logic [TW-1:0]              scaled;
    logic [SW-1:0]              span_idx;
    logic                       too_few;
    logic                       at_end;
    logic                       load_in_range;
    pcks_pkg::t_entry           entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= pcks_pkg::KNOT_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_knot_count <= i_cfg_data;
        end
    end

    always_comb begin
        knots_used = r_knot_count;
        if (32'(r_knot_count) > MAX_KNOTS) begin
            knots_used = pcks_pkg::CFG_W'(MAX_KNOTS);
        end
        too_few = knots_used < pcks_pkg::MIN_KNOTS;
        spans   = knots_used - pcks_pkg::SPAN_OFFSET;

        if (i_in.position[pcks_pkg::DATA_W-1]) begin
            pos_clamped = '0;
        end else if ($unsigned(i_in.position) > ONE_FX) begin
            pos_clamped = PW'(ONE_FX);
        end else begin
            pos_clamped = PW'($unsigned(i_in.position));
        end

        scaled   = TW'(pos_clamped) * TW'(spans);
        span_idx = scaled[TW-1:FRAC_BITS];
        at_end   = span_idx >= SW'(spans);

        entry.op   = pcks_pkg::OP_LOAD;
        entry.addr = pcks_pkg::ADDR_W'(i_in.knot_index);
        entry.data = i_in.knot_value;
        if (i_in.command == pcks_pkg::CMD_EVAL) begin
            if (too_few) begin
                entry.op = pcks_pkg::OP_ERR;
            end else if (at_end) begin
                // top end returns the last knot in use as is
                entry.op   = pcks_pkg::OP_LAST;
                entry.addr = pcks_pkg::ADDR_W'(knots_used - 7'd1);
            end else begin
                entry.op   = pcks_pkg::OP_EVAL;
                entry.addr = pcks_pkg::ADDR_W'(span_idx);
                entry.data = pcks_pkg::DATA_W'(scaled[FRAC_BITS-1:0]);
            end
        end

        load_in_range = 32'(i_in.knot_index) < MAX_KNOTS;
    end

    // loads past the table are taken and dropped
    assign o_push_valid = i_in.valid &&
                          ((i_in.command == pcks_pkg::CMD_EVAL) || load_in_range);
    assign o_push_data  = entry;
    assign i_in.ready   = i_push_ready;

endmodule

// ----- hw/rtl/pcks_fifo.sv -----
// ----------------------------------------------------------------------------
// pcks_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module pcks_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  pcks_pkg::t_entry  i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output pcks_pkg::t_entry  o_pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    pcks_pkg::t_entry    r_slot [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_slot[r_wr_ptr] <= i_push_data;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/pcks_back.sv -----
// ----------------------------------------------------------------------------
// pcks_back
// Knot memory and evaluation sequencer: four window reads, coefficient
// setup, three horner steps on one multiplier, saturation, result register.
// ----------------------------------------------------------------------------
`include "piecewise_cubic_knot_spline_unit_defines.svh"

module pcks_back #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  pcks_pkg::t_entry  i_pop_data,
    pcks_out_if.source        o_out
);

    localparam int AW    = $clog2(MAX_KNOTS);
    localparam int DW    = pcks_pkg::DATA_W;
    localparam int ACC_W = pcks_pkg::ACC_W;
    localparam int PW    = ACC_W + FRAC_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_READ,
        S_COEF,
        S_MUL,
        S_ADD
    } t_state;

    localparam logic [1:0] LAST_READ = 2'd3;
    localparam logic [1:0] LAST_STEP = 2'd2;

    logic [DW-1:0]              r_mem [MAX_KNOTS];
    logic signed [DW-1:0]       r_rd_data;

    t_state                     r_state;
    logic [1:0]                 r_cnt;
    logic [1:0]                 r_step;
    logic [AW-1:0]              r_base;
    logic [FRAC_BITS-1:0]       r_frac;
    logic signed [DW-1:0]       r_k0;
    logic signed [DW-1:0]       r_k1;
    logic signed [DW-1:0]       r_k2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_c2;
    logic signed [ACC_W-1:0]    r_c1;
    logic signed [ACC_W-1:0]    r_c0;
    logic signed [PW-1:0]       r_prod;
    logic                       r_out_valid;
    logic signed [DW-1:0]       r_out_value;
    logic                       r_out_status;

    logic                       out_free;
    logic                       out_load;
    logic                       pop;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              rd_addr;
    logic signed [ACC_W-1:0]    k0;
    logic signed [ACC_W-1:0]    k1;
    logic signed [ACC_W-1:0]    k2;
    logic signed [ACC_W-1:0]    k3;
    logic signed [ACC_W-1:0]    d_a;
    logic signed [ACC_W-1:0]    d_b;
    logic signed [ACC_W-1:0]    d_c;
    logic signed [ACC_W-1:0]    c3;
    logic signed [ACC_W-1:0]    c2;
    logic signed [ACC_W-1:0]    c1;
    logic signed [ACC_W-1:0]    coef;
    logic signed [ACC_W-1:0]    acc_next;
    logic [ACC_W-DW:0]          acc_top;
    logic signed [DW-1:0]       acc_sat;

    assign out_free    = !r_out_valid || o_out.ready;
    assign o_pop_ready = (r_state == S_IDLE) &&
                         ((i_pop_data.op != pcks_pkg::OP_ERR) || out_free);
    assign pop         = i_pop_valid && o_pop_ready;
    assign mem_we      = pop && (i_pop_data.op == pcks_pkg::OP_LOAD);

    // a new result goes into the output register this cycle
    assign out_load    = (pop && (i_pop_data.op == pcks_pkg::OP_ERR)) ||
                         ((r_state == S_LAST) && out_free) ||
                         ((r_state == S_ADD) && (r_step == LAST_STEP) && out_free);

    always_comb begin
        case (r_state)
            S_IDLE: begin
                rd_addr = i_pop_data.addr[AW-1:0];
                mem_re  = pop && ((i_pop_data.op == pcks_pkg::OP_EVAL) ||
                                  (i_pop_data.op == pcks_pkg::OP_LAST));
            end
            S_READ: begin
                rd_addr = r_base + AW'(r_cnt);
                mem_re  = 1'b1;
            end
            default: begin
                rd_addr = r_base;
                mem_re  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_pop_data.addr[AW-1:0]] <= i_pop_data.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // power-basis coefficients of the bezier window, k3 straight from the read port
    always_comb begin
        k0  = ACC_W'(r_k0);
        k1  = ACC_W'(r_k1);
        k2  = ACC_W'(r_k2);
        k3  = ACC_W'(r_rd_data);
        d_a = k1 - k2;
        d_b = k0 - (k1 <<< 1) + k2;
        d_c = k1 - k0;
        c3  = (k3 - k0) + (d_a <<< 1) + d_a;
        c2  = (d_b <<< 1) + d_b;
        c1  = (d_c <<< 1) + d_c;
    end

    // floor of product / 2^frac after the half offset rounds ties upward
    always_comb begin
        case (r_step)
            2'd0:    coef = r_c2;
            2'd1:    coef = r_c1;
            default: coef = r_c0;
        endcase
        acc_next = $signed(r_prod[FRAC_BITS +: ACC_W]) + coef;
        acc_top  = acc_next[ACC_W-1:DW-1];
        if ((acc_top == '0) || (acc_top == '1)) begin
            acc_sat = acc_next[DW-1:0];
        end else if (acc_next[ACC_W-1]) begin
            acc_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (i_pop_data.op)
                            pcks_pkg::OP_ERR: begin
                                r_out_valid  <= 1'b1;
                                r_out_value  <= '0;
                                r_out_status <= 1'b1;
                            end
                            pcks_pkg::OP_LAST: begin
                                r_state <= S_LAST;
                            end
                            pcks_pkg::OP_EVAL: begin
                                r_base  <= i_pop_data.addr[AW-1:0];
                                r_frac  <= i_pop_data.data[FRAC_BITS-1:0];
                                r_cnt   <= 2'd1;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LAST: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_rd_data;
                        r_out_status <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_READ: begin
                    // data of the previous address lands this cycle
                    case (r_cnt)
                        2'd1:    r_k0 <= r_rd_data;
                        2'd2:    r_k1 <= r_rd_data;
                        default: r_k2 <= r_rd_data;
                    endcase
                    if (r_cnt == LAST_READ) begin
                        r_state <= S_COEF;
                    end else begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                S_COEF: begin
                    r_acc   <= c3;
                    r_c2    <= c2;
                    r_c1    <= c1;
                    r_c0    <= k0;
                    r_step  <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= (r_acc * $signed({1'b0, r_frac})) +
                               $signed(PW'(1) <<< (FRAC_BITS - 1));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_step == LAST_STEP) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_value  <= acc_sat;
                            r_out_status <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_acc   <= acc_next;
                        r_step  <= r_step + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.spline_value = r_out_value;
    assign o_out.status       = r_out_status;

    `PCKS_ASSERT_IMPL(a_err_gives_zero, i_clk, i_rst_n, r_out_valid && r_out_status, r_out_value == '0)
    `PCKS_ASSERT_NEXT(a_coef_then_mul, i_clk, i_rst_n, r_state == S_COEF, r_state == S_MUL)
    `PCKS_ASSERT_NEXT(a_mul_then_add, i_clk, i_rst_n, r_state == S_MUL, r_state == S_ADD)
    `PCKS_ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_state == S_MUL || r_state == S_ADD, r_step != 2'd3)

endmodule

// ----- hw/rtl/piecewise_cubic_knot_spline_unit.sv -----
// ----------------------------------------------------------------------------
// piecewise_cubic_knot_spline_unit
// Usage:
//   i_in carries load items (command 0: knot_index, knot_value) and evaluate
//   items (command 1: position, Q16.16 by default); o_out returns one
//   spline_value/status item per evaluate and nothing per load.
//   knot_count is written through i_cfg_we/i_cfg_data while the unit is idle.
//   The front end accepts one item per cycle into a two-entry queue as long
//   as the queue has room, independent of the back end.
//   The back end retires a load straight into the knot table. An evaluate
//   occupies it for four reads through the knot memory's single read port,
//   coefficient setup and three multiply/add horner passes on one shared
//   multiplier. A top-end position reads the last knot in use into the result
//   register; a too-few-knots error goes straight into the result register.
//   Reset empties the queue, drops any pending result and sets knot_count to
//   four; the knot table is not cleared and must be loaded before use.
//   When o_out.ready is low the result register holds; the back end stalls
//   at its next result and the queue then fills and drops i_in.ready.
// ----------------------------------------------------------------------------
module piecewise_cubic_knot_spline_unit #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pcks_pkg::CFG_W-1:0]  i_cfg_data,
    pcks_in_if.sink                     i_in,
    pcks_out_if.source                  o_out
);

    logic              push_valid;
    logic              push_ready;
    pcks_pkg::t_entry  push_data;
    logic              pop_valid;
    logic              pop_ready;
    pcks_pkg::t_entry  pop_data;

    pcks_front #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    pcks_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pcks_back #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

// ----- verif/piecewise_cubic_knot_spline_unit_test.sv -----
// ----------------------------------------------------------------------------
// piecewise_cubic_knot_spline_unit_test
// Self-checking bench for the knot spline unit: fills the knot table, walks a
// table of directed loads, evaluates and knot_count writes, then runs random
// phases, most under random source gaps and sink stalls. Each result is compared
// against its typed value or a fixed-point Bezier predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module piecewise_cubic_knot_spline_unit_test;

    localparam int     MAX_KNOTS     = 64;
    localparam int     FRAC_BITS     = 16;
    localparam longint ONE_FX        = longint'(1) << FRAC_BITS;
    localparam longint FRAC_MASK     = ONE_FX - 1;
    localparam longint HALF_LSB      = ONE_FX >>> 1;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     LONG_HOLD     = 80;
    localparam int     PHASES        = 10;
    localparam int     PHASE_ITEMS   = 117;
    localparam int     N_DIRECTED    = 26;

    typedef struct packed {
        logic signed [pcks_pkg::DATA_W-1:0] value;
        logic                               status;
    } t_spline_result;

    typedef enum logic [1:0] {
        STEP_LOAD,
        STEP_EVAL,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind                   kind;
        logic [pcks_pkg::IDX_W-1:0]   idx;
        logic [pcks_pkg::DATA_W-1:0]  value;      // knot value, or knot_count for a write
        logic [pcks_pkg::DATA_W-1:0]  pos;
        logic                         typed;
        logic [pcks_pkg::DATA_W-1:0]  exp_value;
        logic                         exp_status;
    } t_directed_step;

    // typed rows hold results that follow directly from the window, the clamp or a too-few-knots error
    t_directed_step directed_steps [N_DIRECTED] = '{
        '{STEP_LOAD, 6'd0,  32'h8000_0000, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_LOAD, 6'd1,  32'h7FFF_FFFF, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_LOAD, 6'd2,  32'h8000_0000, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_LOAD, 6'd3,  32'h7FFF_FFFF, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_8000, 1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_FFFF, 1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0001_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_0001, 1'b0, 32'h0,         1'b0},
        '{STEP_LOAD, 6'd63, 32'h0001_2345, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_CFG,  6'd0,  32'd64,        32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0001_0000, 1'b1, 32'h0001_2345, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_ABCD, 1'b0, 32'h0,         1'b0},
        '{STEP_CFG,  6'd0,  32'd127,       32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0001_0000, 1'b1, 32'h0001_2345, 1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_FFFF, 1'b0, 32'h0,         1'b0},
        '{STEP_CFG,  6'd0,  32'd3,         32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_8000, 1'b1, 32'h0,         1'b1},
        '{STEP_CFG,  6'd0,  32'd0,         32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0001_0000, 1'b1, 32'h0,         1'b1},
        '{STEP_CFG,  6'd0,  32'd4,         32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_LOAD, 6'd2,  32'hFFFE_0000, 32'h0,         1'b0, 32'h0,         1'b0},
        '{STEP_EVAL, 6'd0,  32'h0,         32'h0000_4000, 1'b0, 32'h0,         1'b0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [pcks_pkg::CFG_W-1:0]  i_cfg_data;

    pcks_in_if  in_ch ();
    pcks_out_if out_ch ();

    piecewise_cubic_knot_spline_unit #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic signed [pcks_pkg::DATA_W-1:0] knot_mirror [MAX_KNOTS];
    logic [pcks_pkg::CFG_W-1:0]         knot_count_mirror;
    t_spline_result                     expected_results [$];
    int                                 mismatch_count = 0;
    bit                                 source_gaps_on = 1'b0;
    bit                                 sink_stalls_on = 1'b0;
    bit                                 hold_long_req  = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint horner_round(input longint p);
        // nearest, ties toward plus infinity
        return (p + HALF_LSB) >>> FRAC_BITS;
    endfunction

    function automatic t_spline_result predict_spline(
        input logic signed [pcks_pkg::DATA_W-1:0] position
    );
        t_spline_result res;
        int             n;
        int             spans;
        int             span;
        longint         pos;
        longint         t;
        longint         f;
        longint         k0;
        longint         k1;
        longint         k2;
        longint         k3;
        longint         acc;
        n = int'(knot_count_mirror);
        if (n > MAX_KNOTS) n = MAX_KNOTS;
        res.value  = '0;
        res.status = 1'b1;
        if (n < int'(pcks_pkg::MIN_KNOTS)) return res;
        res.status = 1'b0;
        spans = n - int'(pcks_pkg::SPAN_OFFSET);
        pos = position;
        if (pos < 0) pos = 0;
        if (pos > ONE_FX) pos = ONE_FX;
        t = pos * spans;
        span = int'(t >>> FRAC_BITS);
        if (span >= spans) begin
            res.value = knot_mirror[n-1];
            return res;
        end
        f  = t & FRAC_MASK;
        k0 = knot_mirror[span];
        k1 = knot_mirror[span+1];
        k2 = knot_mirror[span+2];
        k3 = knot_mirror[span+3];
        // power-basis coefficients of the bezier cubic, highest power first
        acc = -k0 + 3*k1 - 3*k2 + k3;
        acc = horner_round(acc * f) + (3*k0 - 6*k1 + 3*k2);
        acc = horner_round(acc * f) + (3*k1 - 3*k0);
        acc = horner_round(acc * f) + k0;
        if (acc > longint'(32'sh7FFF_FFFF)) res.value = 32'h7FFF_FFFF;
        else if (acc < longint'(32'sh8000_0000)) res.value = 32'h8000_0000;
        else res.value = 32'(acc);
        return res;
    endfunction

    function automatic logic [pcks_pkg::DATA_W-1:0] random_knot();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return 32'($urandom_range(0, 32'h0000_FFFF)) - 32'h0000_8000;
        endcase
    endfunction

    function automatic logic [pcks_pkg::DATA_W-1:0] random_position();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0;
            1: return $urandom;
            2: return $urandom | 32'h8000_0000;
            3: return 32'h0001_0000 - $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0001_0000);
        endcase
    endfunction

    function automatic logic [pcks_pkg::CFG_W-1:0] random_knot_count();
        case ($urandom_range(0, 6))
            0: return pcks_pkg::CFG_W'($urandom_range(0, 3));
            1: return pcks_pkg::CFG_W'($urandom_range(65, 127));
            2: return pcks_pkg::MIN_KNOTS;
            default: return pcks_pkg::CFG_W'($urandom_range(4, 64));
        endcase
    endfunction

    task automatic offer_item(input logic cmd, input logic [pcks_pkg::IDX_W-1:0] idx,
                              input logic [pcks_pkg::DATA_W-1:0] value,
                              input logic [pcks_pkg::DATA_W-1:0] pos,
                              input bit typed = 1'b0,
                              input t_spline_result typed_res = '0);
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.knot_index <= idx;
        in_ch.knot_value <= value;
        in_ch.position   <= pos;
        do @(posedge i_clk); while (!in_ch.ready);
        if (cmd == pcks_pkg::CMD_LOAD) knot_mirror[idx] = value;
        else if (typed) expected_results.push_back(typed_res);
        else expected_results.push_back(predict_spline(pos));
    endtask

    task automatic pause_source(input int cycles);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // a trailing load gives no result, so let the back end settle as well
    task automatic wait_for_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_knot_count(input logic [pcks_pkg::CFG_W-1:0] count);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        knot_count_mirror = count;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        if ($urandom_range(0, 3) == 0)
            offer_item(pcks_pkg::CMD_LOAD, pcks_pkg::IDX_W'($urandom_range(0, 63)),
                       random_knot(), $urandom);
        else
            offer_item(pcks_pkg::CMD_EVAL, pcks_pkg::IDX_W'($urandom), $urandom,
                       random_position());
    endtask

    // result side: random stall bursts plus one long hold on request
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long_req) begin
                hold_long_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_spline_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: spline_value 0x%08h status %0d",
                       out_ch.spline_value, out_ch.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.spline_value !== want.value) begin
                    $error("spline_value mismatch: expected 0x%08h, got 0x%08h",
                           want.value, out_ch.spline_value);
                    mismatch_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, out_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_directed_step step;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.command    = pcks_pkg::CMD_LOAD;
        in_ch.knot_index = '0;
        in_ch.knot_value = '0;
        in_ch.position   = '0;
        knot_count_mirror = pcks_pkg::KNOT_COUNT_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every slot written before any evaluate can read it
        for (int i = 0; i < MAX_KNOTS; i++)
            offer_item(pcks_pkg::CMD_LOAD, pcks_pkg::IDX_W'(i), random_knot(), $urandom);

        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            case (step.kind)
                STEP_CFG:  write_knot_count(step.value[pcks_pkg::CFG_W-1:0]);
                STEP_LOAD: offer_item(pcks_pkg::CMD_LOAD, step.idx, step.value, $urandom);
                default:   offer_item(pcks_pkg::CMD_EVAL, pcks_pkg::IDX_W'($urandom),
                                      $urandom, step.pos,
                                      step.typed, '{step.exp_value, step.exp_status});
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            write_knot_count(random_knot_count());
            if (phase == PHASES - 1) begin
                source_gaps_on = 1'b0;
                sink_stalls_on = 1'b0;
            end else begin
                source_gaps_on = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            // sink holds off while the source keeps offering, so the input backs up
            if (phase == 2) begin
                source_gaps_on = 1'b0;
                hold_long_req  = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == PHASE_ITEMS / 2) wait_for_results();
                if (source_gaps_on && $urandom_range(0, 5) == 0)
                    pause_source($urandom_range(1, 9));
                random_item();
            end
        end

        wait_for_results();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
